// ===== hdl/lphash_pkg.sv =====
// lphash_pkg: shared types, codes and sizes of the linear probing hash table
// used by lphash_ctrl, lphash_dp and linear_probe_hash_table
`timescale 1ns / 1ps
`default_nettype none

package lphash_pkg;

    localparam int SLOTS         = 16;
    localparam int KEY_BITS      = 31;
    localparam int SLOT_BITS     = $clog2(SLOTS);
    localparam int CNT_BITS      = SLOT_BITS + 1;
    localparam int CFG_BITS      = 5;
    localparam int CFG_RESET     = 10;
    localparam int OUT_SLOT_BITS = 4;
    localparam int MOD_STEPS     = (KEY_BITS + 1) / 2;
    localparam int DIV_BITS      = 2 * MOD_STEPS;
    localparam int STEP_BITS     = $clog2(MOD_STEPS);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_GONE  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       mod_step;
        logic       probe_start;
        logic       probe_next;
        logic       ins_write;
        logic       del_write;
        logic       res_load;
        logic [1:0] res_status;
        logic       out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       mod_last;
        logic       lap_last;
        logic       slot_free;
        logic       slot_empty;
        logic       key_hit;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lphash_ram.sv =====
// lphash_ram: generic single write port, single read port ram
// registered read data, no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lphash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/lphash_ctrl.sv =====
// lphash_ctrl: sequencer for modulo, probe and result hand-off
// depends on lphash_pkg
`timescale 1ns / 1ps
`default_nettype none

module lphash_ctrl
    import lphash_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_HOME  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.res_status = STATUS_MISSING;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                cmd.probe_start = 1'b1;
                if (stat.op == CMD_UNUSED)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                cmd.res_load = 1'b1;
                if (stat.op == CMD_INSERT)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.ins_write  = 1'b1;
                        cmd.res_status = STATUS_OK;
                    end
                    else if (stat.lap_last)
                    begin
                        cmd.res_status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.res_load   = 1'b0;
                        cmd.probe_next = 1'b1;
                        state_next     = S_READ;
                    end
                end
                else
                begin
                    if (stat.slot_empty)
                    begin
                        cmd.res_status = STATUS_MISSING;
                    end
                    else if (stat.key_hit)
                    begin
                        cmd.res_status = STATUS_OK;
                        cmd.del_write  = (stat.op == CMD_DELETE);
                    end
                    else if (stat.lap_last)
                    begin
                        cmd.res_status = STATUS_MISSING;
                    end
                    else
                    begin
                        cmd.res_load   = 1'b0;
                        cmd.probe_next = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lphash_dp.sv =====
// lphash_dp: slot count register, two bit per cycle modulo, probe pointer,
// slot marks, key ram and result registers; depends on lphash_pkg, lphash_ram
`timescale 1ns / 1ps
`default_nettype none

module lphash_dp
    import lphash_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wen,
    input  wire logic [CFG_BITS-1:0]      cfg_wdata,
    input  wire logic [1:0]               in_cmd,
    input  wire logic [KEY_BITS-1:0]      in_key,
    input  wire ctrl_cmd_t                cmd,
    output dp_stat_t                      stat,
    output logic [1:0]                    out_status,
    output logic [OUT_SLOT_BITS-1:0]      out_slot
);

    logic [CFG_BITS-1:0]      slots_reg;
    logic [1:0]               op_reg;
    logic [KEY_BITS-1:0]      key_reg;
    logic [DIV_BITS-1:0]      div_reg, div_next;
    logic [SLOT_BITS-1:0]     rem_reg, rem_next;
    logic [STEP_BITS-1:0]     step_reg;
    logic [SLOT_BITS-1:0]     at_reg, at_next;
    logic [SLOT_BITS-1:0]     probe_reg;
    logic [1:0]               res_status_reg;
    logic [SLOT_BITS-1:0]     res_slot_reg;
    logic [1:0]               out_status_reg;
    logic [OUT_SLOT_BITS-1:0] out_slot_reg;
    logic [1:0]               mark_reg [SLOTS];
    logic [CNT_BITS-1:0]      n_eff;
    logic [CNT_BITS-1:0]      r1, r2, r1_sub;
    logic [CNT_BITS-1:0]      at_inc;
    logic [KEY_BITS-1:0]      ram_rdata;
    logic [1:0]               cur_mark;

    // clamp the slot count into 1..SLOTS
    always_comb
    begin
        if (slots_reg == '0)
        begin
            n_eff = CNT_BITS'(1);
        end
        else if (CNT_BITS'(slots_reg) > CNT_BITS'(SLOTS))
        begin
            n_eff = CNT_BITS'(SLOTS);
        end
        else
        begin
            n_eff = CNT_BITS'(slots_reg);
        end
    end

    // two restoring steps of key mod n per cycle
    always_comb
    begin
        r1       = {rem_reg, div_reg[DIV_BITS-1]};
        r1_sub   = (r1 >= n_eff) ? (r1 - n_eff) : r1;
        r2       = {r1_sub[SLOT_BITS-1:0], div_reg[DIV_BITS-2]};
        rem_next = (r2 >= n_eff) ? SLOT_BITS'(r2 - n_eff) : r2[SLOT_BITS-1:0];
        div_next = {div_reg[DIV_BITS-3:0], 2'b00};
    end

    always_comb
    begin
        at_inc  = CNT_BITS'(at_reg) + CNT_BITS'(1);
        at_next = (at_inc >= n_eff) ? '0 : at_inc[SLOT_BITS-1:0];
    end

    assign cur_mark = mark_reg[at_reg];

    assign stat.op         = op_reg;
    assign stat.mod_last   = (step_reg == STEP_BITS'(MOD_STEPS - 1));
    assign stat.lap_last   = (CNT_BITS'(probe_reg) == (n_eff - CNT_BITS'(1)));
    assign stat.slot_free  = (cur_mark != MARK_USED);
    assign stat.slot_empty = (cur_mark == MARK_EMPTY);
    assign stat.key_hit    = (cur_mark == MARK_USED) && (ram_rdata == key_reg);

    lphash_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.ins_write),
        .waddr (at_reg),
        .wdata (key_reg),
        .raddr (at_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= CFG_BITS'(CFG_RESET);
            for (int i = 0; i < SLOTS; i++)
            begin
                mark_reg[i] <= MARK_EMPTY;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                slots_reg <= cfg_wdata;
            end
            if (cmd.ins_write)
            begin
                mark_reg[at_reg] <= MARK_USED;
            end
            else if (cmd.del_write)
            begin
                mark_reg[at_reg] <= MARK_GONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= in_cmd;
            key_reg  <= in_key;
            div_reg  <= DIV_BITS'(in_key);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            div_reg  <= div_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_BITS'(1);
        end
        if (cmd.probe_start)
        begin
            at_reg    <= rem_reg;
            probe_reg <= '0;
        end
        if (cmd.probe_next)
        begin
            at_reg    <= at_next;
            probe_reg <= probe_reg + SLOT_BITS'(1);
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= (cmd.res_status == STATUS_OK) ? at_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= OUT_SLOT_BITS'(res_slot_reg);
        end
    end

    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
// linear_probe_hash_table: top level, controller plus datapath
// depends on lphash_pkg, lphash_ctrl, lphash_dp, lphash_ram
//
//  channel    | dir | signals                  | beat holds
//  -----------+-----+--------------------------+-------------------------------
//  s_axis     | in  | s_tvalid s_tready s_tdata| cmd, key
//  m_axis     | out | m_tvalid m_tready m_tdata| status, slot_index
//  cfg        | in  | cfg_wen cfg_wdata        | slots_in_use
//
// an item passes through accept, the modulo steps (two quotient bits a cycle),
// the home step, a read and a check per probed slot (key ram registered read)
// and the hand-off; the number of probed slots runs from 1 to the clamped slot
// count, and an unused command skips the probes
// one item is in flight at a time; a finished result waits in the output
// register while the next beat is accepted
// reset clears all slot marks at once, slot count resets to 10
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table
    import lphash_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [39:0]         s_tdata,   // cmd[1:0], key[32:2], zero pad
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // status[1:0], slot_index[5:2], zero pad
    input  wire logic                cfg_wen,
    input  wire logic [CFG_BITS-1:0] cfg_wdata
);

    ctrl_cmd_t                cmd;
    dp_stat_t                 stat;
    logic [1:0]               out_status;
    logic [OUT_SLOT_BITS-1:0] out_slot;

    lphash_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lphash_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_cmd     (s_tdata[1:0]),
        .in_key     (s_tdata[KEY_BITS+1:2]),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (out_status),
        .out_slot   (out_slot)
    );

    assign m_tdata = {2'b00, out_slot, out_status};

    // a failed operation never reports a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != STATUS_OK)) |-> (m_tdata[5:2] == '0))
        else $error("nonzero slot_index with failing status");

    // status code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code on output");

    // after a beat is taken the block is busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // if no result is waiting at an accept, none is shown in the cycle right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared before the item was processed");

endmodule

`default_nettype wire
